@@ hdl/nsc_pkg.sv @@
// Shared constants for the NMEA sentence checker: status codes, characters, defaults.
package nsc_pkg;

  localparam int unsigned MaxLenDefault = 256;

  localparam logic [2:0] StatusOk         = 3'd0;
  localparam logic [2:0] StatusNoDollar   = 3'd1;
  localparam logic [2:0] StatusNoChecksum = 3'd2;
  localparam logic [2:0] StatusUnreadable = 3'd3;
  localparam logic [2:0] StatusMismatch   = 3'd4;
  localparam logic [2:0] StatusTooLong    = 3'd5;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;

endpackage

@@ hdl/nmea_sentence_checker_top.sv @@
// NMEA sentence checker: per-byte checksum and field tracking with one registered result.
//
// Input channel (in_valid, in_stall, data_byte, last_byte) carries one sentence byte
// per transfer; last_byte marks the final byte of a sentence. Output channel
// (out_valid, out_stall, status, computed_sum, received_sum, field_count) carries
// one result per sentence, produced by the transfer whose last_byte is set.
// Throughput is one byte per cycle while in_stall is low: the running sums and counters
// update in the cycle of the transfer, and the result register is loaded at that same
// edge, so the result appears on the output in the cycle after the final byte is taken.
// Bytes that are not the final one are taken even while a result waits in the
// output register. A final byte is held off (in_stall high) only while the output
// register is full and out_stall is high, so no result is ever overwritten.
// Reset clears the sentence state and empties the output register; the block is
// ready for the first '$' in the next cycle. After each result the sentence state
// returns to its reset values.
module nmea_sentence_checker_top #(
  parameter int unsigned MAX_LEN = nsc_pkg::MaxLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  computed_sum,
  output logic [31:0] received_sum,
  output logic [7:0]  field_count
);

  localparam int unsigned CountW = $clog2(MAX_LEN + 1);
  localparam logic [CountW-1:0] MaxLenC = CountW'(MAX_LEN);

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_BODY,
    PH_CKSUM,
    PH_ENDED
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [31:0]        hex_value, hex_value_next;
  logic [3:0]         hex_digits, hex_digits_next;
  logic               hex_ended, hex_ended_next;
  logic [7:0]         comma_count, comma_count_next;
  logic [CountW-1:0]  byte_count, byte_count_next;
  logic               bad_start, bad_start_next;
  logic               star_seen, star_seen_next;
  logic               after_any, after_any_next;
  logic               after_text, after_text_next;
  logic               too_long, too_long_next;

  logic               in_xfer;
  logic               is_hex;
  logic [3:0]         hex_nibble;
  logic               is_space;
  logic               empty_tail;
  logic [2:0]         status_next;

  assign in_stall = out_valid && out_stall && last_byte;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    is_hex     = 1'b1;
    hex_nibble = 4'd0;
    if (data_byte >= nsc_pkg::ChZero && data_byte <= nsc_pkg::ChNine) begin
      hex_nibble = data_byte[3:0];
    end else if (data_byte >= nsc_pkg::ChLowerA && data_byte <= nsc_pkg::ChLowerF) begin
      hex_nibble = data_byte[3:0] + 4'd9;
    end else if (data_byte >= nsc_pkg::ChUpperA && data_byte <= nsc_pkg::ChUpperF) begin
      hex_nibble = data_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_space = (data_byte == nsc_pkg::ChSpace) ||
                    (data_byte >= nsc_pkg::ChTab && data_byte <= nsc_pkg::ChCr);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    hex_value_next   = hex_value;
    hex_digits_next  = hex_digits;
    hex_ended_next   = hex_ended;
    comma_count_next = comma_count;
    byte_count_next  = byte_count;
    bad_start_next   = bad_start;
    star_seen_next   = star_seen;
    after_any_next   = after_any;
    after_text_next  = after_text;
    too_long_next    = too_long;

    priority if (phase == PH_AWAIT) begin
      if (data_byte != nsc_pkg::ChDollar) begin
        bad_start_next = 1'b1;
        phase_next     = PH_ENDED;
      end else begin
        if (byte_count >= MaxLenC) too_long_next = 1'b1;
        else byte_count_next = byte_count + CountW'(1);
        phase_next = PH_BODY;
      end
    end else if (phase != PH_ENDED && data_byte == nsc_pkg::ChNul) begin
      phase_next = PH_ENDED;
    end else if (phase == PH_BODY) begin
      if (byte_count >= MaxLenC) too_long_next = 1'b1;
      else byte_count_next = byte_count + CountW'(1);
      if (data_byte == nsc_pkg::ChStar) begin
        star_seen_next = 1'b1;
        phase_next     = PH_CKSUM;
      end else begin
        running_xor_next = running_xor ^ data_byte;
        if (data_byte == nsc_pkg::ChComma && comma_count != 8'hFF) begin
          comma_count_next = comma_count + 8'd1;
        end
      end
    end else if (phase == PH_CKSUM) begin
      if (byte_count >= MaxLenC) too_long_next = 1'b1;
      else byte_count_next = byte_count + CountW'(1);
      after_any_next = 1'b1;
      if (data_byte != nsc_pkg::ChCr && data_byte != nsc_pkg::ChLf) begin
        after_text_next = 1'b1;
      end
      if (!hex_ended) begin
        if (is_hex) begin
          hex_value_next = {hex_value[27:0], hex_nibble};
          if (hex_digits != 4'hF) hex_digits_next = hex_digits + 4'd1;
        end else if (hex_digits != 4'd0 || !is_space) begin
          hex_ended_next = 1'b1;
        end
      end
    end else begin
      phase_next = phase;
    end
  end

  assign empty_tail = (phase_next == PH_ENDED) ? !after_any_next : !after_text_next;

  always_comb begin
    priority if (bad_start_next) status_next = nsc_pkg::StatusNoDollar;
    else if (too_long_next) status_next = nsc_pkg::StatusTooLong;
    else if (!star_seen_next || empty_tail) status_next = nsc_pkg::StatusNoChecksum;
    else if (hex_digits_next == 4'd0) status_next = nsc_pkg::StatusUnreadable;
    else if (hex_value_next != {24'd0, running_xor_next}) begin
      status_next = nsc_pkg::StatusMismatch;
    end else status_next = nsc_pkg::StatusOk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_AWAIT;
      running_xor <= 8'd0;
      hex_value   <= 32'd0;
      hex_digits  <= 4'd0;
      hex_ended   <= 1'b0;
      comma_count <= 8'd0;
      byte_count  <= '0;
      bad_start   <= 1'b0;
      star_seen   <= 1'b0;
      after_any   <= 1'b0;
      after_text  <= 1'b0;
      too_long    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer && last_byte) begin
        phase       <= PH_AWAIT;
        running_xor <= 8'd0;
        hex_value   <= 32'd0;
        hex_digits  <= 4'd0;
        hex_ended   <= 1'b0;
        comma_count <= 8'd0;
        byte_count  <= '0;
        bad_start   <= 1'b0;
        star_seen   <= 1'b0;
        after_any   <= 1'b0;
        after_text  <= 1'b0;
        too_long    <= 1'b0;
      end else if (in_xfer) begin
        phase       <= phase_next;
        running_xor <= running_xor_next;
        hex_value   <= hex_value_next;
        hex_digits  <= hex_digits_next;
        hex_ended   <= hex_ended_next;
        comma_count <= comma_count_next;
        byte_count  <= byte_count_next;
        bad_start   <= bad_start_next;
        star_seen   <= star_seen_next;
        after_any   <= after_any_next;
        after_text  <= after_text_next;
        too_long    <= too_long_next;
      end
      if (in_xfer && last_byte) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register on the final byte of a sentence.
  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      status       <= status_next;
      computed_sum <= running_xor_next;
      received_sum <= hex_value_next;
      field_count  <= comma_count_next;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the NMEA sentence checker: directed and random sentences.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxLen = nsc_pkg::MaxLenDefault;
  localparam int CycleLimit = 200000;

  typedef enum logic [1:0] {SeekDollar, InBody, InChecksum, ContentEnded} scan_phase_t;

  typedef struct {
    logic [2:0]  code;
    logic [7:0]  xor_sum;
    logic [31:0] hex_sum;
    logic [7:0]  commas;
  } sentence_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  computed_sum;
  logic [31:0] received_sum;
  logic [7:0]  field_count;

  scan_phase_t scan_phase;
  logic [7:0]  xor_acc;
  logic [31:0] hex_acc;
  logic [3:0]  hex_count;
  logic        hex_done;
  logic [7:0]  comma_acc;
  int unsigned content_len;
  logic        bad_lead;
  logic        star_found;
  logic        tail_any;
  logic        tail_text;
  logic        overlong;

  sentence_report_t pending_reports[$];
  sentence_report_t want;
  logic [7:0]       frame_bytes[$];
  int               error_count = 0;
  int               bytes_sent = 0;
  int               cycle_count = 0;
  bit               sender_gaps = 1'b1;
  bit               receiver_gaps = 1'b1;

  nmea_sentence_checker_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .computed_sum (computed_sum),
    .received_sum (received_sum),
    .field_count  (field_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL nmea_sentence_checker_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= receiver_gaps && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (status !== want.code) begin
          $display("%0t: status expected %0d actual %0d", $time, want.code, status);
          error_count++;
        end
        if (computed_sum !== want.xor_sum) begin
          $display("%0t: computed_sum expected %h actual %h", $time, want.xor_sum,
                   computed_sum);
          error_count++;
        end
        if (received_sum !== want.hex_sum) begin
          $display("%0t: received_sum expected %h actual %h", $time, want.hex_sum,
                   received_sum);
          error_count++;
        end
        if (field_count !== want.commas) begin
          $display("%0t: field_count expected %0d actual %0d", $time, want.commas,
                   field_count);
          error_count++;
        end
      end
    end
  end

  task automatic clear_sentence();
    scan_phase = SeekDollar;
    xor_acc = 8'h00;
    hex_acc = 32'h0;
    hex_count = 4'd0;
    hex_done = 1'b0;
    comma_acc = 8'h00;
    content_len = 0;
    bad_lead = 1'b0;
    star_found = 1'b0;
    tail_any = 1'b0;
    tail_text = 1'b0;
    overlong = 1'b0;
  endtask

  task automatic count_content_byte();
    if (content_len >= MaxLen) overlong = 1'b1;
    else content_len++;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic lst);
    int digit;
    logic empty;
    logic blank;
    sentence_report_t rep;
    digit = -1;
    if (b >= nsc_pkg::ChZero && b <= nsc_pkg::ChNine) begin
      digit = int'(b - nsc_pkg::ChZero);
    end else if (b >= nsc_pkg::ChLowerA && b <= nsc_pkg::ChLowerF) begin
      digit = int'(b - nsc_pkg::ChLowerA) + 10;
    end else if (b >= nsc_pkg::ChUpperA && b <= nsc_pkg::ChUpperF) begin
      digit = int'(b - nsc_pkg::ChUpperA) + 10;
    end
    blank = (b == nsc_pkg::ChSpace) || (b >= nsc_pkg::ChTab && b <= nsc_pkg::ChCr);
    if (scan_phase == SeekDollar) begin
      if (b != nsc_pkg::ChDollar) begin
        bad_lead = 1'b1;
        scan_phase = ContentEnded;
      end else begin
        count_content_byte();
        scan_phase = InBody;
      end
    end else if (scan_phase != ContentEnded && b == nsc_pkg::ChNul) begin
      scan_phase = ContentEnded;
    end else if (scan_phase == InBody) begin
      count_content_byte();
      if (b == nsc_pkg::ChStar) begin
        star_found = 1'b1;
        scan_phase = InChecksum;
      end else begin
        xor_acc ^= b;
        if (b == nsc_pkg::ChComma && comma_acc != 8'hFF) comma_acc++;
      end
    end else if (scan_phase == InChecksum) begin
      count_content_byte();
      tail_any = 1'b1;
      if (b != nsc_pkg::ChCr && b != nsc_pkg::ChLf) tail_text = 1'b1;
      if (!hex_done) begin
        if (digit >= 0) begin
          hex_acc = {hex_acc[27:0], 4'(digit)};
          if (hex_count != 4'd15) hex_count++;
        end else if (hex_count != 4'd0 || !blank) begin
          hex_done = 1'b1;
        end
      end
    end
    if (lst) begin
      empty = (scan_phase == ContentEnded) ? !tail_any : !tail_text;
      if (bad_lead) rep.code = nsc_pkg::StatusNoDollar;
      else if (overlong) rep.code = nsc_pkg::StatusTooLong;
      else if (!star_found || empty) rep.code = nsc_pkg::StatusNoChecksum;
      else if (hex_count == 4'd0) rep.code = nsc_pkg::StatusUnreadable;
      else if (hex_acc != {24'h0, xor_acc}) rep.code = nsc_pkg::StatusMismatch;
      else rep.code = nsc_pkg::StatusOk;
      rep.xor_sum = xor_acc;
      rep.hex_sum = hex_acc;
      rep.commas = comma_acc;
      pending_reports.push_back(rep);
      clear_sentence();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (sender_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, lst);
    bytes_sent++;
  endtask

  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic add_hex(input logic [31:0] v, input int ndig, input bit lower);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = (i < 8) ? 4'(v >> (4 * i)) : 4'($urandom_range(15));
      if (nib < 4'd10) begin
        frame_bytes.push_back(nsc_pkg::ChZero + {4'd0, nib});
      end else begin
        frame_bytes.push_back(
          (lower ? nsc_pkg::ChLowerA : nsc_pkg::ChUpperA) + {4'd0, nib} - 8'd10);
      end
    end
  endtask

  function automatic logic [7:0] frame_xor();
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 1; i < frame_bytes.size(); i++) acc ^= frame_bytes[i];
    return acc;
  endfunction

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic test_valid_sentences();
    add_text("$GPGGA,123519,4807.038,N");
    add_text("*");
    add_hex(frame_xor(), 2, 1'b0);
    frame_bytes.push_back(nsc_pkg::ChCr);
    frame_bytes.push_back(nsc_pkg::ChLf);
    send_frame();
    add_text("$GPRMC,a,b");
    frame_bytes.push_back(nsc_pkg::ChStar);
    frame_bytes.push_back(nsc_pkg::ChSpace);
    frame_bytes.push_back(nsc_pkg::ChTab);
    add_hex({24'h0, frame_xor() ^ nsc_pkg::ChStar}, 2, 1'b1);
    send_frame();
    frame_bytes.push_back(nsc_pkg::ChDollar);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h80);
    frame_bytes.push_back(8'h01);
    add_hex(frame_xor(), 0, 1'b0);
    frame_bytes.push_back(nsc_pkg::ChStar);
    add_hex({24'h0, frame_xor() ^ nsc_pkg::ChStar}, 2, 1'b0);
    frame_bytes.push_back(nsc_pkg::ChCr);
    frame_bytes.push_back(nsc_pkg::ChLf);
    send_frame();
    add_text("$X,Y*");
    add_hex({24'h0, frame_xor() ^ nsc_pkg::ChStar}, 10, 1'b0);
    send_frame();
  endtask

  task automatic test_bad_start();
    add_text("GPGGA,1*00");
    send_frame();
    frame_bytes.push_back(nsc_pkg::ChNul);
    add_text("$A*41");
    send_frame();
    frame_bytes.push_back(8'hFF);
    send_frame();
  endtask

  task automatic test_missing_checksum();
    add_text("$");
    send_frame();
    add_text("$AB,C");
    frame_bytes.push_back(nsc_pkg::ChCr);
    frame_bytes.push_back(nsc_pkg::ChLf);
    send_frame();
    add_text("$AB*");
    frame_bytes.push_back(nsc_pkg::ChCr);
    frame_bytes.push_back(nsc_pkg::ChLf);
    send_frame();
    add_text("$AB*");
    frame_bytes.push_back(nsc_pkg::ChNul);
    add_text("12");
    send_frame();
    add_text("$AB");
    frame_bytes.push_back(nsc_pkg::ChNul);
    add_text("*03");
    send_frame();
  endtask

  task automatic test_bad_checksum_text();
    add_text("$AB*zz");
    send_frame();
    add_text("$AB*-3");
    send_frame();
    add_text("$AB*  ");
    send_frame();
    add_text("$AB*0x03");
    send_frame();
    add_text("$A*4*1");
    send_frame();
    add_text("$AB*FF");
    send_frame();
  endtask

  task automatic test_length_limit();
    frame_bytes.push_back(nsc_pkg::ChDollar);
    repeat (MaxLen - 4) frame_bytes.push_back(nsc_pkg::ChUpperA);
    frame_bytes.push_back(nsc_pkg::ChStar);
    add_hex({24'h0, frame_xor() ^ nsc_pkg::ChStar}, 2, 1'b0);
    send_frame();
    frame_bytes.push_back(nsc_pkg::ChDollar);
    repeat (MaxLen - 3) frame_bytes.push_back(nsc_pkg::ChUpperA);
    frame_bytes.push_back(nsc_pkg::ChStar);
    add_hex({24'h0, frame_xor() ^ nsc_pkg::ChStar}, 2, 1'b0);
    send_frame();
    frame_bytes.push_back(nsc_pkg::ChDollar);
    repeat (MaxLen + 44) frame_bytes.push_back(nsc_pkg::ChComma);
    add_text("*00");
    send_frame();
  endtask

  task automatic test_random_traffic(input int byte_budget);
    int stop_at;
    int kind;
    int body_len;
    int pad;
    int ndig;
    logic [7:0] c;
    logic [7:0] body_sum;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      body_len = ($urandom_range(49) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 24);
      if (kind < 12) begin
        repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(255)));
      end else begin
        frame_bytes.push_back(kind < 18 ? 8'($urandom_range(255)) : nsc_pkg::ChDollar);
        repeat (body_len) begin
          case ($urandom_range(9))
            0, 1: c = nsc_pkg::ChComma;
            2: c = 8'($urandom_range(1, 255));
            default: c = 8'($urandom_range(8'h20, 8'h7E));
          endcase
          if (c == nsc_pkg::ChStar) c = nsc_pkg::ChComma;
          frame_bytes.push_back(c);
        end
        body_sum = frame_xor();
        if (kind < 28) begin
          case ($urandom_range(3))
            0: ;
            1: begin
              frame_bytes.push_back(nsc_pkg::ChStar);
              frame_bytes.push_back(8'($urandom_range(255)));
            end
            2: begin
              frame_bytes.push_back(nsc_pkg::ChNul);
              add_text("*00");
            end
            default: frame_bytes.push_back(nsc_pkg::ChStar);
          endcase
        end else begin
          frame_bytes.push_back(nsc_pkg::ChStar);
          pad = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
          repeat (pad) begin
            frame_bytes.push_back($urandom_range(1) ? nsc_pkg::ChSpace : nsc_pkg::ChTab);
          end
          if ($urandom_range(7) == 0) body_sum ^= 8'($urandom_range(1, 255));
          ndig = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : 2;
          add_hex({24'h0, body_sum}, ndig, $urandom_range(1));
          if ($urandom_range(3) != 0) begin
            frame_bytes.push_back(nsc_pkg::ChCr);
            frame_bytes.push_back(nsc_pkg::ChLf);
          end
          if ($urandom_range(15) == 0) frame_bytes.push_back(nsc_pkg::ChNul);
        end
      end
      send_frame();
    end
  endtask

  initial begin
    clear_sentence();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_valid_sentences();
    test_bad_start();
    test_missing_checksum();
    wait_reports_drained();
    test_bad_checksum_text();
    test_length_limit();
    wait_reports_drained();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_traffic(150);
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    test_random_traffic(330);
    wait_reports_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("PASS nmea_sentence_checker_top");
    else $display("FAIL nmea_sentence_checker_top");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/nsc_pkg.sv
hdl/nmea_sentence_checker_top.sv
tb/sv/tb.sv
